FILE: rtl/core/ctw_pkg.sv
// Shared types and constants for the census transform window block.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package ctw_pkg;

  localparam int PIX_W      = 8;
  localparam int CODE_W     = 16;
  localparam int ROW_W      = 10;
  localparam int DIM_W      = 11;
  localparam int THR_W      = 9;
  localparam int ROW_LIMIT  = 1024;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_THR    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                    mode;
    logic signed [THR_W-1:0] thr;
  } census_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/ctw_line_buf.sv
// One row of the line store: simple dual-port RAM with registered read.
// Depends on ctw_pkg for the pixel type.
`default_nettype none

module ctw_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire ctw_pkg::pixel_t wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output ctw_pkg::pixel_t      rdata_o
);

  ctw_pkg::pixel_t mem [DEPTH];
  ctw_pkg::pixel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/ctw_win_cell.sv
// One window column cell: holds a vertical strip of pixels and passes it on.
// Depends on ctw_pkg for the pixel width.
`default_nettype none

module ctw_win_cell #(
  parameter int ROWS = 3
) (
  input  wire logic                               clk_i,
  input  wire logic                               shift_i,
  input  wire logic [ROWS-1:0][ctw_pkg::PIX_W-1:0] col_i,
  output logic      [ROWS-1:0][ctw_pkg::PIX_W-1:0] col_o
);

  logic [ROWS-1:0][ctw_pkg::PIX_W-1:0] col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

FILE: rtl/core/ctw_census.sv
// Parallel neighbor-versus-center compare over the window, packed into the code.
// Depends on ctw_pkg for widths and the control struct.
`default_nettype none

module ctw_census #(
  parameter int ROWS = 3,
  parameter int COLS = 5
) (
  input  wire logic [COLS-1:0][ROWS-1:0][ctw_pkg::PIX_W-1:0] win_i,
  input  wire ctw_pkg::census_ctrl_t                         ctrl_i,
  output logic [ctw_pkg::CODE_W-1:0]                         code_o
);

  localparam int HALF_R = ROWS / 2;
  localparam int HALF_C = COLS / 2;
  localparam int CTR_POS = HALF_R * COLS + HALF_C;

  // window cell k holds column offset -(k - HALF_C); x runs left to right
  always_comb begin
    logic [ctw_pkg::PIX_W-1:0] ctr;
    logic [ctw_pkg::PIX_W-1:0] nb;
    logic signed [ctw_pkg::PIX_W+1:0] diff;
    logic signed [ctw_pkg::PIX_W+1:0] thr;
    logic hit;
    int pos;
    int bitn;
    ctr    = win_i[COLS-1-HALF_C][HALF_R];
    thr    = (ctw_pkg::PIX_W+2)'(ctrl_i.thr);
    code_o = '0;
    for (int j = 0; j < ROWS; j++) begin
      for (int x = 0; x < COLS; x++) begin
        pos  = j * COLS + x;
        bitn = (pos < CTR_POS) ? pos : pos - 1;
        nb   = win_i[COLS-1-x][j];
        diff = $signed({2'b00, nb}) - $signed({2'b00, ctr});
        hit  = ctrl_i.mode ? (diff > thr) : (nb < ctr);
        if (pos != CTR_POS && bitn < ctw_pkg::CODE_W) begin
          code_o[4'(bitn)] = hit;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/census_transform_window.sv
// Streaming census transform. Pixels enter in raster order, one per clock while
// in_ready_o is high, and each transfer yields one registered result: the census
// code of the pixel half a window up and half a window to the left, or 0 with
// interior low on the border. Throughput is one pixel per clock without output
// stalls: one write to one line buffer and one read of each per pixel. The window
// is a chain of column cells that shift one column per pixel. Line buffers are
// not cleared. Depends on ctw_pkg, ctw_line_buf, ctw_win_cell and ctw_census.
`default_nettype none

module census_transform_window #(
  parameter int WIN_W    = 5,
  parameter int WIN_H    = 3,
  parameter int MAX_LINE = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [ctw_pkg::PIX_W-1:0]          pixel_i,
  input  wire logic                               start_of_frame_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  output logic [ctw_pkg::CODE_W-1:0]              census_code_o,
  output logic                                    interior_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ctw_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [ctw_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [ctw_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready
);

  localparam int HALF_W = WIN_W / 2;
  localparam int HALF_H = WIN_H / 2;
  localparam int NC     = 2 * HALF_W + 1;
  localparam int NR     = 2 * HALF_H + 1;
  localparam int CW     = $clog2(MAX_LINE);
  localparam int WW     = $clog2(MAX_LINE + 1);
  localparam int CMPW   = (WW > ctw_pkg::DIM_W) ? WW : ctw_pkg::DIM_W;
  localparam int PHW    = (WIN_H > 1) ? $clog2(WIN_H) : 1;
  localparam int DW     = ctw_pkg::DIM_W;
  localparam int RW     = ctw_pkg::ROW_W;

  // ---------------- configuration registers ----------------
  logic                         mode_q;
  logic [ctw_pkg::THR_W-1:0]    thr_q;
  logic [DW-1:0]                width_q;
  logic [DW-1:0]                height_q;
  logic                         cfg_wr;
  ctw_pkg::reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = ctw_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      thr_q    <= '0;
      width_q  <= ctw_pkg::WIDTH_RESET;
      height_q <= ctw_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ctw_pkg::REG_MODE:   mode_q   <= pwdata[0];
        ctw_pkg::REG_THR:    thr_q    <= pwdata[ctw_pkg::THR_W-1:0];
        ctw_pkg::REG_WIDTH:  width_q  <= pwdata[DW-1:0];
        ctw_pkg::REG_HEIGHT: height_q <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ctw_pkg::REG_MODE:   prdata = ctw_pkg::APB_DATA_W'(mode_q);
      ctw_pkg::REG_THR:    prdata = ctw_pkg::APB_DATA_W'(thr_q);
      ctw_pkg::REG_WIDTH:  prdata = ctw_pkg::APB_DATA_W'(width_q);
      ctw_pkg::REG_HEIGHT: prdata = ctw_pkg::APB_DATA_W'(height_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------- pipeline handshake ----------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic adv1, adv2, accept;

  assign adv2       = s2_v_q & (~out_v_q | out_ready_i);
  assign adv1       = s1_v_q & (~s2_v_q | adv2);
  assign in_ready_o = ~s1_v_q | adv1;
  assign accept     = in_valid_i & in_ready_o;

  // ---------------- position counters ----------------
  logic [CW-1:0]   col_q, col_d, c_cur;
  logic [RW-1:0]   row_q, row_d, r_cur;
  logic [PHW-1:0]  ph_q, ph_d, ph_cur;
  logic [CMPW-1:0] w_ext, w_eff, c1;
  logic [DW-1:0]   h_eff, r1;
  logic            inner_cur;

  always_comb begin
    w_ext = CMPW'(width_q);
    if (w_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (w_ext > CMPW'(MAX_LINE)) begin
      w_eff = CMPW'(MAX_LINE);
    end else begin
      w_eff = w_ext;
    end
    if (height_q == '0) begin
      h_eff = DW'(1);
    end else if (height_q > DW'(ctw_pkg::ROW_LIMIT)) begin
      h_eff = DW'(ctw_pkg::ROW_LIMIT);
    end else begin
      h_eff = height_q;
    end
  end

  always_comb begin
    c_cur  = start_of_frame_i ? '0 : col_q;
    r_cur  = start_of_frame_i ? '0 : row_q;
    ph_cur = start_of_frame_i ? '0 : ph_q;

    inner_cur = (DW'(r_cur) >= DW'(2 * HALF_H)) && (CMPW'(c_cur) >= CMPW'(2 * HALF_W)) &&
                (DW'(r_cur) < h_eff) && (CMPW'(c_cur) < w_eff);

    c1 = CMPW'(c_cur) + CMPW'(1);
    r1 = DW'(r_cur) + DW'(1);
    if (c1 >= w_eff) begin
      col_d = '0;
      if (r1 >= h_eff) begin
        row_d = '0;
        ph_d  = '0;
      end else begin
        row_d = r1[RW-1:0];
        ph_d  = (ph_cur == PHW'(WIN_H - 1)) ? '0 : ph_cur + PHW'(1);
      end
    end else begin
      col_d = c1[CW-1:0];
      if (DW'(r_cur) >= h_eff) begin
        row_d = '0;
        ph_d  = '0;
      end else begin
        row_d = r_cur;
        ph_d  = ph_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ph_q  <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      ph_q  <= ph_d;
    end
  end

  // ---------------- stage 1: line buffer read ----------------
  ctw_pkg::pixel_t s1_pix_q;
  logic [PHW-1:0]  s1_ph_q;
  logic            s1_inner_q;
  logic [NR-1:0][ctw_pkg::PIX_W-1:0] col_vec;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pixel_i;
      s1_ph_q    <= ph_cur;
      s1_inner_q <= inner_cur;
    end
  end

  // col_vec[j] is window row dy = j - HALF_H; the bottom row is the live pixel.
  // Rows that land on the current buffer row (even heights) reuse the live pixel.
  if (WIN_H > 1) begin : g_lb
    ctw_pkg::pixel_t rd_data [WIN_H];

    for (genvar p = 0; p < WIN_H; p++) begin : g_row
      ctw_line_buf #(
        .DEPTH (MAX_LINE),
        .AW    (CW)
      ) u_line_buf (
        .clk_i   (clk_i),
        .we_i    (accept && (ph_cur == PHW'(p))),
        .waddr_i (c_cur),
        .wdata_i (pixel_i),
        .re_i    (accept),
        .raddr_i (c_cur),
        .rdata_o (rd_data[p])
      );
    end

    for (genvar j = 0; j < NR; j++) begin : g_sel
      localparam int DM = (NR - 1 - j) % WIN_H;
      if (DM == 0) begin : g_live
        assign col_vec[j] = s1_pix_q;
      end else begin : g_mem
        logic [PHW:0] psum;
        logic [PHW:0] pidx;
        assign psum = {1'b0, s1_ph_q} + (PHW + 1)'(WIN_H - DM);
        assign pidx = (psum >= (PHW + 1)'(WIN_H)) ? psum - (PHW + 1)'(WIN_H) : psum;
        assign col_vec[j] = rd_data[pidx[PHW-1:0]];
      end
    end
  end else begin : g_single
    assign col_vec[0] = s1_pix_q;
  end

  // ---------------- stage 2: window cell chain ----------------
  logic [NC-1:0][NR-1:0][ctw_pkg::PIX_W-1:0] win;
  logic s2_inner_q;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    ctw_win_cell #(
      .ROWS (NR)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (adv1),
      .col_i   ((k == 0) ? col_vec : win[(k == 0) ? 0 : k - 1]),
      .col_o   (win[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_inner_q <= s1_inner_q;
    end
  end

  // ---------------- stage 3: compare and output register ----------------
  ctw_pkg::census_ctrl_t       ctrl;
  logic [ctw_pkg::CODE_W-1:0]  code_raw;
  logic [ctw_pkg::CODE_W-1:0]  code_q;
  logic                        inner_q;

  assign ctrl.mode = mode_q;
  assign ctrl.thr  = $signed(thr_q);

  ctw_census #(
    .ROWS (NR),
    .COLS (NC)
  ) u_census (
    .win_i  (win),
    .ctrl_i (ctrl),
    .code_o (code_raw)
  );

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      code_q  <= s2_inner_q ? code_raw : '0;
      inner_q <= s2_inner_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (adv1) begin
        s1_v_q <= 1'b0;
      end
      if (adv1) begin
        s2_v_q <= 1'b1;
      end else if (adv2) begin
        s2_v_q <= 1'b0;
      end
      if (adv2) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign census_code_o = code_q;
  assign interior_o    = inner_q;

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for census_transform_window: a pixel stream with random
// idling on both sides, checked transfer by transfer against a built-in predictor.
// Depends on ctw_pkg and the census_transform_window RTL.

module testbench;

  localparam int WIN_W       = 5;
  localparam int WIN_H       = 3;
  localparam int MAX_LINE    = 1024;
  localparam int HALF_W      = WIN_W / 2;
  localparam int HALF_H      = WIN_H / 2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {PIX_ANY, PIX_FLAT, PIX_RAIL} pix_style_e;

  typedef struct packed {
    ctw_pkg::pixel_t px;
    logic            sof;
  } pixel_item_t;

  typedef struct packed {
    logic [ctw_pkg::CODE_W-1:0] code;
    logic                       inner;
  } census_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic [ctw_pkg::PIX_W-1:0]      pixel_i          = '0;
  logic                           start_of_frame_i = 1'b0;
  logic                           in_valid_i       = 1'b0;
  logic                           out_ready_i      = 1'b0;
  logic                           psel             = 1'b0;
  logic                           penable          = 1'b0;
  logic                           pwrite           = 1'b0;
  logic [ctw_pkg::APB_ADDR_W-1:0] paddr            = '0;
  logic [ctw_pkg::APB_DATA_W-1:0] pwdata           = '0;
  wire                            in_ready_o;
  wire  [ctw_pkg::CODE_W-1:0]     census_code_o;
  wire                            interior_o;
  wire                            out_valid_o;
  wire  [ctw_pkg::APB_DATA_W-1:0] prdata;
  wire                            pready;

  // shadow of the register file, updated when an APB write completes
  logic                           cfg_mode   = 1'b0;
  logic [ctw_pkg::THR_W-1:0]      cfg_thr    = '0;
  logic [ctw_pkg::DIM_W-1:0]      cfg_width  = ctw_pkg::WIDTH_RESET;
  logic [ctw_pkg::DIM_W-1:0]      cfg_height = ctw_pkg::HEIGHT_RESET;

  ctw_pkg::pixel_t line_mem [WIN_H][MAX_LINE];
  int col_pos = 0;
  int row_pos = 0;

  pixel_item_t pixel_q [$];
  census_res_t code_q [$];

  int  mismatches  = 0;
  int  cycles      = 0;
  int  gap_left    = 0;
  int  stall_left  = 0;
  bit  quiet       = 1'b0;
  bit  pressure_go = 1'b0;
  logic hold_off   = 1'b0;

  census_transform_window #(
    .WIN_W    (WIN_W),
    .WIN_H    (WIN_H),
    .MAX_LINE (MAX_LINE)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pixel_i          (pixel_i),
    .start_of_frame_i (start_of_frame_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .census_code_o    (census_code_o),
    .interior_o       (interior_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #2 clk_i = ~clk_i;

  function automatic int eff_dim(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the line store and counters by one pixel and queue the census result.
  function automatic void predict_census(input ctw_pkg::pixel_t px, input logic sof);
    int w, h, r, c, cr, cc, ctr, nb, dy, dx, nbit;
    logic [ctw_pkg::CODE_W-1:0] code;
    logic inner, hit;
    census_res_t res;
    w = eff_dim(cfg_width, MAX_LINE);
    h = eff_dim(cfg_height, ctw_pkg::ROW_LIMIT);
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    line_mem[r % WIN_H][c % MAX_LINE] = px;
    code  = '0;
    inner = 1'b0;
    if (r >= 2 * HALF_H && c >= 2 * HALF_W && r < h && c < w) begin
      cr    = r - HALF_H;
      cc    = c - HALF_W;
      ctr   = line_mem[cr % WIN_H][cc % MAX_LINE];
      inner = 1'b1;
      nbit  = 0;
      for (dy = -HALF_H; dy <= HALF_H; dy++) begin
        for (dx = -HALF_W; dx <= HALF_W; dx++) begin
          if (dy != 0 || dx != 0) begin
            nb  = line_mem[(cr + dy) % WIN_H][(cc + dx) % MAX_LINE];
            hit = cfg_mode ? ((nb - ctr) > $signed(cfg_thr)) : (nb < ctr);
            // positions past the code width are dropped
            if (hit && nbit < ctw_pkg::CODE_W) code[nbit] = 1'b1;
            nbit++;
          end
        end
      end
    end
    // a counter left beyond a shrunk size wraps on this step
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      if (r >= h) row_pos = 0;
    end
    res.code  = code;
    res.inner = inner;
    code_q.push_back(res);
  endfunction

  function automatic ctw_pkg::pixel_t next_pixel(input pix_style_e style);
    case (style)
      PIX_FLAT: return 8'd126 + 8'($urandom_range(0, 4));
      PIX_RAIL: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:  return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_pixel(input ctw_pkg::pixel_t px, input logic sof);
    pixel_item_t item;
    item.px  = px;
    item.sof = sof;
    pixel_q.push_back(item);
  endtask

  task automatic add_pixels(input int n, input pix_style_e style, input bit sof_first,
                            input bit sof_noise);
    for (int k = 0; k < n; k++) begin
      push_pixel(next_pixel(style),
                 (sof_first && k == 0) || (sof_noise && $urandom_range(0, 199) == 0));
    end
  endtask

  // Frames at the current size, each opened by start_of_frame, until n pixels are queued;
  // with noise some frames are cut short and a stray start_of_frame lands mid-frame.
  task automatic add_frames(input int n, input pix_style_e style, input bit noisy);
    int fsize, len, left;
    fsize = eff_dim(cfg_width, MAX_LINE) * eff_dim(cfg_height, ctw_pkg::ROW_LIMIT);
    left  = n;
    while (left > 0) begin
      len = fsize;
      if (noisy && $urandom_range(0, 9) == 0) len = $urandom_range(1, fsize);
      if (len > left) len = left;
      add_pixels(len, style, 1'b1, noisy);
      left -= len;
    end
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid_i || code_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input ctw_pkg::reg_idx_e idx,
                           input logic [ctw_pkg::APB_DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ctw_pkg::REG_MODE:   cfg_mode   = val[0];
      ctw_pkg::REG_THR:    cfg_thr    = val[ctw_pkg::THR_W-1:0];
      ctw_pkg::REG_WIDTH:  cfg_width  = val[ctw_pkg::DIM_W-1:0];
      ctw_pkg::REG_HEIGHT: cfg_height = val[ctw_pkg::DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic mode, input logic [ctw_pkg::THR_W-1:0] thr,
                            input logic [ctw_pkg::DIM_W-1:0] w,
                            input logic [ctw_pkg::DIM_W-1:0] h);
    wait_idle();
    reg_write(ctw_pkg::REG_MODE,   {31'd0, mode});
    reg_write(ctw_pkg::REG_THR,    {23'd0, thr});
    reg_write(ctw_pkg::REG_WIDTH,  {21'd0, w});
    reg_write(ctw_pkg::REG_HEIGHT, {21'd0, h});
  endtask

  function automatic logic [ctw_pkg::THR_W-1:0] pick_thr();
    case ($urandom_range(0, 5))
      0:       return 9'h100;
      1:       return 9'h0FF;
      2:       return 9'h1FF;
      3:       return 9'h000;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [ctw_pkg::DIM_W-1:0] pick_width();
    case ($urandom_range(0, 7))
      0:       return 11'($urandom_range(0, 4));
      1:       return 11'($urandom_range(13, 40));
      default: return 11'($urandom_range(5, 12));
    endcase
  endfunction

  function automatic logic [ctw_pkg::DIM_W-1:0] pick_height();
    if ($urandom_range(0, 7) == 0) return 11'($urandom_range(0, 2));
    return 11'($urandom_range(3, 8));
  endfunction

  // pixel sender
  always @(posedge clk_i) begin : send_p
    pixel_item_t item;
    logic fire;
    fire = in_valid_i && in_ready_o;
    if (fire) predict_census(pixel_i, start_of_frame_i);
    if (rst_ni && (!in_valid_i || fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        item = pixel_q.pop_front();
        in_valid_i       <= 1'b1;
        pixel_i          <= item.px;
        start_of_frame_i <= item.sof;
        if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 18);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result checker and receiver stalls
  always @(posedge clk_i) begin : recv_p
    census_res_t want;
    logic ready_nxt;
    if (out_valid_o && out_ready_i) begin
      if (code_q.size() == 0) begin
        $display("%0t: result transfer with none expected, code %h interior %b",
                 $time, census_code_o, interior_o);
        mismatches++;
      end else begin
        want = code_q.pop_front();
        if (census_code_o !== want.code) begin
          $display("%0t: census_code expected %h got %h", $time, want.code, census_code_o);
          mismatches++;
        end
        if (interior_o !== want.inner) begin
          $display("%0t: interior expected %b got %b", $time, want.inner, interior_o);
          mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      ready_nxt = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      ready_nxt  = 1'b0;
    end else begin
      ready_nxt = 1'b1;
    end
    out_ready_i <= ready_nxt && !hold_off;
  end

  // long receiver hold-off so the pipeline backs up into the input
  initial begin : hold_p
    wait (pressure_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin : watchdog_p
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("census_transform_window: mismatch");
      $finish;
    end
  end

  initial begin : stim_p
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 5x3 image, standard mode: pixels at both rails around a mid-grey centre
    set_config(1'b0, 9'h000, 11'd5, 11'd3);
    for (int k = 0; k < 15; k++) begin
      push_pixel((k == 7) ? 8'd128 : ((k % 3 == 0) ? 8'h00 : ((k % 3 == 1) ? 8'hFF : 8'd128)),
                 k == 0);
    end
    // frame restarted after two pixels
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h00, 1'b0);
    add_pixels(15, PIX_RAIL, 1'b1, 1'b0);

    // adaptive mode at the threshold extremes and with near-equal pixels
    set_config(1'b1, 9'h100, 11'd5, 11'd3);
    add_frames(15, PIX_ANY, 1'b0);
    set_config(1'b1, 9'h0FF, 11'd5, 11'd3);
    add_frames(15, PIX_RAIL, 1'b0);
    set_config(1'b1, 9'h000, 11'd6, 11'd3);
    add_frames(18, PIX_FLAT, 1'b0);

    // shrink the width, then the height, with the counters past the new sizes
    set_config(1'b0, 9'h000, 11'd8, 11'd6);
    add_pixels(22, PIX_ANY, 1'b1, 1'b0);
    set_config(1'b1, 9'h1FD, 11'd5, 11'd6);
    add_pixels(9, PIX_ANY, 1'b0, 1'b0);
    set_config(1'b1, 9'h1FD, 11'd5, 11'd3);
    add_pixels(12, PIX_FLAT, 1'b0, 1'b0);

    // zero sizes act as one
    set_config(1'b0, 9'h000, 11'd0, 11'd0);
    add_pixels(10, PIX_ANY, 1'b1, 1'b0);

    for (int p = 0; p < 8; p++) begin
      set_config(1'($urandom_range(0, 1)), pick_thr(), pick_width(), pick_height());
      add_frames(35, pix_style_e'($urandom_range(0, 2)), 1'b1);
      if (p == 3) pressure_go = 1'b1;
    end

    // widest line, then an oversized width that clamps to it
    set_config(1'b0, 9'h000, 11'd1024, 11'd3);
    add_pixels(40, PIX_ANY, 1'b1, 1'b0);
    set_config(1'b1, 9'h00A, 11'd2047, 11'd1024);
    add_pixels(24, PIX_ANY, 1'b0, 1'b0);

    // oversized height clamps to the row limit
    wait_idle();
    quiet = 1'b1;
    set_config(1'b0, 9'h000, 11'd5, 11'd2047);
    add_pixels(60, PIX_ANY, 1'b1, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && code_q.size() == 0) begin
      $display("census_transform_window: match");
    end else begin
      $display("census_transform_window: mismatch");
    end
    $finish;
  end

endmodule

FILE: census_transform_window.f
rtl/core/ctw_pkg.sv
rtl/core/ctw_line_buf.sv
rtl/core/ctw_win_cell.sv
rtl/core/ctw_census.sv
rtl/core/census_transform_window.sv
test/testbench.sv
